FILE: rtl/core/avr_pkg.sv
// Shared types, widths and constants for the axis-angle vector rotation unit.
// No dependencies; every rtl/core module refers to it by scoped names.
`default_nettype none
package avr_pkg;

    localparam int VEC_BITS     = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int AXIS_BITS    = 16;
    localparam int TRIG_W       = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int ENT_W        = 32;
    localparam int MAT_LAT      = 3;
    localparam int APPLY_LAT    = 2;
    localparam int TOTAL_LAT    = CORDIC_LAT + MAT_LAT + APPLY_LAT;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] HALF_TURN   = 34'sd2147483648;

    typedef logic signed [VEC_BITS-1:0]  t_vec;
    typedef logic signed [AXIS_BITS-1:0] t_axis;
    typedef logic signed [TRIG_W-1:0]    t_trig;
    typedef logic signed [ENT_W-1:0]     t_ent;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_vec z;
    } t_vec3;

    typedef struct packed {
        t_axis x;
        t_axis y;
        t_axis z;
    } t_axis3;

    typedef struct packed {
        t_vec3  vec;
        t_axis3 axis;
    } t_payload;

    typedef struct packed {
        logic  valid;
        t_trig sn;
        t_trig cs;
    } t_trig_out;

    typedef struct packed {
        t_ent m11;
        t_ent m12;
        t_ent m13;
        t_ent m21;
        t_ent m22;
        t_ent m23;
        t_ent m31;
        t_ent m32;
        t_ent m33;
    } t_mat;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic t_trig atan_turn(input logic [4:0] idx);
        t_trig r;
        case (idx)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/avr_cordic.sv
// Pipelined rotation-mode CORDIC: one stage per iteration, sine and cosine in Q.30.
// Depends on avr_pkg.
`default_nettype none
module avr_cordic (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [avr_pkg::ANGLE_BITS-1:0]  i_angle,
    output avr_pkg::t_trig_out                   o_trig
);

    localparam int N = avr_pkg::CORDIC_STEPS;

    logic [31:0]    w_turn;
    logic [31:0]    w_neg;
    avr_pkg::t_trig w_z0;
    avr_pkg::t_trig w_z;
    logic           w_flip;

    logic           r_v [0:N];
    avr_pkg::t_trig r_x [0:N];
    avr_pkg::t_trig r_y [0:N];
    avr_pkg::t_trig r_z [0:N];
    logic           r_f [0:N];

    logic           r_out_v;
    avr_pkg::t_trig r_sn;
    avr_pkg::t_trig r_cs;

    // negate the angle, then fold it into +-quarter turn
    always_comb begin
        w_turn = {i_angle, {(32-avr_pkg::ANGLE_BITS){1'b0}}};
        w_neg  = 32'd0 - w_turn;
        w_z0   = avr_pkg::TRIG_W'(signed'(w_neg));
        w_z    = w_z0;
        w_flip = 1'b0;
        if (w_z0 > avr_pkg::ONE_Q30) begin
            w_z    = w_z0 - avr_pkg::HALF_TURN;
            w_flip = 1'b1;
        end else if (w_z0 < -avr_pkg::ONE_Q30) begin
            w_z    = w_z0 + avr_pkg::HALF_TURN;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0] <= avr_pkg::CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= w_z;
        r_f[0] <= w_flip;
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        avr_pkg::t_trig w_dx;
        avr_pkg::t_trig w_dy;
        avr_pkg::t_trig w_at;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = avr_pkg::atan_turn(5'(i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (!r_z[i][avr_pkg::TRIG_W-1]) begin
                r_x[i+1] <= r_x[i] - w_dx;
                r_y[i+1] <= r_y[i] + w_dy;
                r_z[i+1] <= r_z[i] - w_at;
            end else begin
                r_x[i+1] <= r_x[i] + w_dx;
                r_y[i+1] <= r_y[i] - w_dy;
                r_z[i+1] <= r_z[i] + w_at;
            end
            r_f[i+1] <= r_f[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[N];
        end
        r_sn <= r_f[N] ? -r_y[N] : r_y[N];
        r_cs <= r_f[N] ? -r_x[N] : r_x[N];
    end

    assign o_trig.valid = r_out_v;
    assign o_trig.sn    = r_sn;
    assign o_trig.cs    = r_cs;

endmodule
`default_nettype wire

FILE: rtl/core/avr_matrix.sv
// Three-stage build of the Q.24 rotation matrix from axis, sine and cosine.
// Depends on avr_pkg; the vector rides along with the matrix.
`default_nettype none
module avr_matrix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire avr_pkg::t_trig_out i_trig,
    input  wire avr_pkg::t_payload  i_pay,
    output logic                    o_valid,
    output avr_pkg::t_mat           o_mat,
    output avr_pkg::t_vec3          o_vec
);

    localparam int PW = 2 * avr_pkg::AXIS_BITS;
    localparam int SPW = avr_pkg::AXIS_BITS + avr_pkg::TRIG_W;
    localparam int QW = PW + avr_pkg::TRIG_W;
    localparam int SW = SPW - 14;
    localparam int RW = QW - 28;

    localparam logic signed [SPW-1:0] RND14 = SPW'(1) <<< 13;
    localparam logic signed [QW-1:0]  RND28 = QW'(1) <<< 27;
    localparam logic signed [RW-1:0]  RND6  = RW'(32);

    // stage A: axis products, sine products, one minus cosine
    logic                 r_a_v;
    logic signed [PW-1:0] r_a_pxx, r_a_pyy, r_a_pzz, r_a_pxy, r_a_pxz, r_a_pyz;
    logic signed [SPW-1:0] r_a_sx, r_a_sy, r_a_sz;
    avr_pkg::t_trig       r_a_omc, r_a_cs;
    avr_pkg::t_vec3       r_a_vec;

    // stage B: products with one minus cosine, rounded sine terms
    logic                 r_b_v;
    logic signed [QW-1:0] r_b_qxx, r_b_qyy, r_b_qzz, r_b_qxy, r_b_qxz, r_b_qyz;
    logic signed [SW-1:0] r_b_sx, r_b_sy, r_b_sz;
    avr_pkg::t_trig       r_b_cs;
    avr_pkg::t_vec3       r_b_vec;

    // stage C: entries
    logic                 r_c_v;
    avr_pkg::t_mat        r_c_mat;
    avr_pkg::t_vec3       r_c_vec;

    logic signed [RW-1:0] w_cxx, w_cyy, w_czz, w_cxy, w_cxz, w_cyz;
    logic signed [RW-1:0] w_sx, w_sy, w_sz, w_cs;
    avr_pkg::t_mat        w_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_trig.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
        r_a_pxx <= PW'(i_pay.axis.x) * PW'(i_pay.axis.x);
        r_a_pyy <= PW'(i_pay.axis.y) * PW'(i_pay.axis.y);
        r_a_pzz <= PW'(i_pay.axis.z) * PW'(i_pay.axis.z);
        r_a_pxy <= PW'(i_pay.axis.x) * PW'(i_pay.axis.y);
        r_a_pxz <= PW'(i_pay.axis.x) * PW'(i_pay.axis.z);
        r_a_pyz <= PW'(i_pay.axis.y) * PW'(i_pay.axis.z);
        r_a_sx  <= SPW'(i_pay.axis.x) * SPW'(i_trig.sn);
        r_a_sy  <= SPW'(i_pay.axis.y) * SPW'(i_trig.sn);
        r_a_sz  <= SPW'(i_pay.axis.z) * SPW'(i_trig.sn);
        r_a_omc <= avr_pkg::ONE_Q30 - i_trig.cs;
        r_a_cs  <= i_trig.cs;
        r_a_vec <= i_pay.vec;

        r_b_qxx <= QW'(r_a_pxx) * QW'(r_a_omc);
        r_b_qyy <= QW'(r_a_pyy) * QW'(r_a_omc);
        r_b_qzz <= QW'(r_a_pzz) * QW'(r_a_omc);
        r_b_qxy <= QW'(r_a_pxy) * QW'(r_a_omc);
        r_b_qxz <= QW'(r_a_pxz) * QW'(r_a_omc);
        r_b_qyz <= QW'(r_a_pyz) * QW'(r_a_omc);
        r_b_sx  <= SW'((r_a_sx + RND14) >>> 14);
        r_b_sy  <= SW'((r_a_sy + RND14) >>> 14);
        r_b_sz  <= SW'((r_a_sz + RND14) >>> 14);
        r_b_cs  <= r_a_cs;
        r_b_vec <= r_a_vec;

        r_c_mat <= w_mat;
        r_c_vec <= r_b_vec;
    end

    always_comb begin
        w_cxx = RW'((r_b_qxx + RND28) >>> 28);
        w_cyy = RW'((r_b_qyy + RND28) >>> 28);
        w_czz = RW'((r_b_qzz + RND28) >>> 28);
        w_cxy = RW'((r_b_qxy + RND28) >>> 28);
        w_cxz = RW'((r_b_qxz + RND28) >>> 28);
        w_cyz = RW'((r_b_qyz + RND28) >>> 28);
        w_sx  = RW'(r_b_sx);
        w_sy  = RW'(r_b_sy);
        w_sz  = RW'(r_b_sz);
        w_cs  = RW'(r_b_cs);
        w_mat.m11 = avr_pkg::ENT_W'((w_cxx + w_cs + RND6) >>> 6);
        w_mat.m22 = avr_pkg::ENT_W'((w_cyy + w_cs + RND6) >>> 6);
        w_mat.m33 = avr_pkg::ENT_W'((w_czz + w_cs + RND6) >>> 6);
        w_mat.m12 = avr_pkg::ENT_W'((w_cxy - w_sz + RND6) >>> 6);
        w_mat.m13 = avr_pkg::ENT_W'((w_cxz + w_sy + RND6) >>> 6);
        w_mat.m21 = avr_pkg::ENT_W'((w_cxy + w_sz + RND6) >>> 6);
        w_mat.m23 = avr_pkg::ENT_W'((w_cyz - w_sx + RND6) >>> 6);
        w_mat.m31 = avr_pkg::ENT_W'((w_cxz - w_sy + RND6) >>> 6);
        w_mat.m32 = avr_pkg::ENT_W'((w_cyz + w_sx + RND6) >>> 6);
    end

    assign o_valid = r_c_v;
    assign o_mat   = r_c_mat;
    assign o_vec   = r_c_vec;

endmodule
`default_nettype wire

FILE: rtl/core/avr_apply.sv
// Two-stage matrix-vector product with rounding to Q16.16 and saturation.
// Depends on avr_pkg.
`default_nettype none
module avr_apply (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire avr_pkg::t_mat  i_mat,
    input  wire avr_pkg::t_vec3 i_vec,
    output logic                o_valid,
    output avr_pkg::t_vec3      o_rot,
    output logic                o_clipped
);

    localparam int PW = avr_pkg::VEC_BITS + avr_pkg::ENT_W;
    localparam int SW = PW + 2;
    localparam int RW = SW - 24;

    localparam logic signed [SW-1:0] RND24  = SW'(1) <<< 23;
    localparam logic signed [RW-1:0] SAT_HI = (RW'(1) <<< (avr_pkg::VEC_BITS-1)) - RW'(1);
    localparam logic signed [RW-1:0] SAT_LO = -(RW'(1) <<< (avr_pkg::VEC_BITS-1));

    logic                 r_d_v;
    logic signed [PW-1:0] r_d_p [0:8];

    logic                 r_e_v;
    avr_pkg::t_vec3       r_e_rot;
    logic                 r_e_clip;

    logic signed [RW-1:0] w_rx, w_ry, w_rz;
    logic [2:0]           w_clip;
    avr_pkg::t_vec3       w_rot;

    // clamp one component to the output range; top bit flags a clamp
    function automatic logic [avr_pkg::VEC_BITS:0] sat(input logic signed [RW-1:0] v);
        logic [avr_pkg::VEC_BITS:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, avr_pkg::VEC_BITS'(SAT_HI)};
        end else if (v < SAT_LO) begin
            r = {1'b1, avr_pkg::VEC_BITS'(SAT_LO)};
        end else begin
            r = {1'b0, avr_pkg::VEC_BITS'(v)};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_d_v <= i_valid;
            r_e_v <= r_d_v;
        end
        r_d_p[0] <= PW'(i_vec.x) * PW'(i_mat.m11);
        r_d_p[1] <= PW'(i_vec.y) * PW'(i_mat.m21);
        r_d_p[2] <= PW'(i_vec.z) * PW'(i_mat.m31);
        r_d_p[3] <= PW'(i_vec.x) * PW'(i_mat.m12);
        r_d_p[4] <= PW'(i_vec.y) * PW'(i_mat.m22);
        r_d_p[5] <= PW'(i_vec.z) * PW'(i_mat.m32);
        r_d_p[6] <= PW'(i_vec.x) * PW'(i_mat.m13);
        r_d_p[7] <= PW'(i_vec.y) * PW'(i_mat.m23);
        r_d_p[8] <= PW'(i_vec.z) * PW'(i_mat.m33);
        r_e_rot  <= w_rot;
        r_e_clip <= |w_clip;
    end

    always_comb begin
        w_rx = RW'((SW'(r_d_p[0]) + SW'(r_d_p[1]) + SW'(r_d_p[2]) + RND24) >>> 24);
        w_ry = RW'((SW'(r_d_p[3]) + SW'(r_d_p[4]) + SW'(r_d_p[5]) + RND24) >>> 24);
        w_rz = RW'((SW'(r_d_p[6]) + SW'(r_d_p[7]) + SW'(r_d_p[8]) + RND24) >>> 24);
        {w_clip[0], w_rot.x} = sat(w_rx);
        {w_clip[1], w_rot.y} = sat(w_ry);
        {w_clip[2], w_rot.z} = sat(w_rz);
    end

    assign o_valid   = r_e_v;
    assign o_rot     = r_e_rot;
    assign o_clipped = r_e_clip;

endmodule
`default_nettype wire

FILE: rtl/core/axis_angle_vector_rotate_unit.sv
// Top level of the axis-angle vector rotation unit.
// Depends on avr_pkg, avr_cordic, avr_matrix and avr_apply.
//
// Usage:
//   A request is taken at each rising edge with start high and busy low.
//   busy stays low: the pipeline takes one request every cycle.
//   Each request carries a Q16.16 vector, a Q1.14 unit axis and a binary
//   angle (65536 per turn); the vector is rotated right-handed about the axis.
//   o_valid pulses for one cycle with o_rot_x/y/z and o_clipped once the
//   request has passed the sine/cosine CORDIC (one iteration per stage),
//   then the matrix build, then the multiply and sum.
//   Throughput is one result per cycle; results come in request order.
//   o_clipped is set when any component was clamped to the 32-bit range.
//   The receiver cannot stall; results must be taken as they appear.
//   Synchronous reset clears all valid bits; requests in flight are dropped.
`default_nettype none
module axis_angle_vector_rotate_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [avr_pkg::VEC_BITS-1:0]  i_vec_x,
    input  wire logic signed [avr_pkg::VEC_BITS-1:0]  i_vec_y,
    input  wire logic signed [avr_pkg::VEC_BITS-1:0]  i_vec_z,
    input  wire logic signed [avr_pkg::AXIS_BITS-1:0] i_axis_x,
    input  wire logic signed [avr_pkg::AXIS_BITS-1:0] i_axis_y,
    input  wire logic signed [avr_pkg::AXIS_BITS-1:0] i_axis_z,
    input  wire logic [avr_pkg::ANGLE_BITS-1:0]       i_turn_angle,
    output logic                                   o_valid,
    output logic signed [avr_pkg::VEC_BITS-1:0]    o_rot_x,
    output logic signed [avr_pkg::VEC_BITS-1:0]    o_rot_y,
    output logic signed [avr_pkg::VEC_BITS-1:0]    o_rot_z,
    output logic                                   o_clipped
);

    localparam int D = avr_pkg::CORDIC_LAT;

    avr_pkg::t_payload  w_pay_in;
    avr_pkg::t_payload  r_dly [0:D-1];
    avr_pkg::t_trig_out w_trig;
    logic               w_mat_v;
    avr_pkg::t_mat      w_mat;
    avr_pkg::t_vec3     w_vec;
    avr_pkg::t_vec3     w_rot;
    logic               w_take;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_pay_in.vec.x  = i_vec_x;
    assign w_pay_in.vec.y  = i_vec_y;
    assign w_pay_in.vec.z  = i_vec_z;
    assign w_pay_in.axis.x = i_axis_x;
    assign w_pay_in.axis.y = i_axis_y;
    assign w_pay_in.axis.z = i_axis_z;

    // hold vector and axis alongside the CORDIC
    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_pay_in;
        for (int k = 1; k < D; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    avr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_angle (i_turn_angle),
        .o_trig  (w_trig)
    );

    avr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (w_trig),
        .i_pay   (r_dly[D-1]),
        .o_valid (w_mat_v),
        .o_mat   (w_mat),
        .o_vec   (w_vec)
    );

    avr_apply u_apply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_mat_v),
        .i_mat     (w_mat),
        .i_vec     (w_vec),
        .o_valid   (o_valid),
        .o_rot     (w_rot),
        .o_clipped (o_clipped)
    );

    assign o_rot_x = w_rot.x;
    assign o_rot_y = w_rot.y;
    assign o_rot_z = w_rot.z;

    localparam logic signed [avr_pkg::VEC_BITS-1:0] VMAX = {1'b0, {(avr_pkg::VEC_BITS-1){1'b1}}};
    localparam logic signed [avr_pkg::VEC_BITS-1:0] VMIN = {1'b1, {(avr_pkg::VEC_BITS-1){1'b0}}};

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##(avr_pkg::TOTAL_LAT) o_valid)
        else $error("request did not produce a result at the pipeline latency");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_take, avr_pkg::TOTAL_LAT))
        else $error("result without a matching request");

    a_clip_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_rot_x == VMAX || o_rot_x == VMIN || o_rot_y == VMAX ||
             o_rot_y == VMIN || o_rot_z == VMAX || o_rot_z == VMIN))
        else $error("clip flag set but no component at a range end");

endmodule
`default_nettype wire
